>>> hw/rtl/urpw_pkg.sv
// urpw_pkg: shared types and constants of the user range page walk checker.
// Holds the controller state type, request, status and register codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package urpw_pkg;

  // request kinds
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CHECK = 2'd2;
  localparam logic [1:0] REQ_PERM  = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_BOUNDS = 2'd1;
  localparam logic [1:0] STAT_FAULT  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_LOW  = 2'd0;
  localparam logic [1:0] CFG_HIGH = 2'd1;
  localparam logic [1:0] CFG_ROOT = 2'd2;

  localparam logic [31:0] LOW_RESET  = 32'h0040_0000;
  localparam logic [32:0] HIGH_RESET = 33'h0_C000_0000;

  // entry bits
  localparam int BIT_PRESENT = 0;
  localparam int BIT_WRITE   = 1;
  localparam int BIT_USER    = 2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RDATA,
    S_BOUND,
    S_LIMIT,
    S_DIR,
    S_DIRW,
    S_TABW
  } state_t;

endpackage : urpw_pkg

`default_nettype wire

>>> hw/rtl/urpw_mem.sv
// urpw_mem: single port entry memory, one write or one read per cycle.
// Read data is registered (read-first).
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module urpw_mem #(
  parameter int WORDS = 65536,
  parameter int AW    = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [31:0]   wdata,
  output logic      [31:0]   rdata
);

  logic [31:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule : urpw_mem

`default_nettype wire

>>> hw/rtl/user_range_page_walk_check_top.sv
// user_range_page_walk_check_top: entry memory plus walk controller for
// user range checks and writable-bit updates over two-level page tables.
// Depends on urpw_pkg and urpw_mem.
//
//  port group      dir  handshake             word
//  request         in   start & !busy         req_type .. space_root
//  result          out  done (one cycle)      read_data, status
//  config          in   cfg_we                cfg_index, cfg_data
//
// Word write: done the cycle after accept, busy stays low. Word read: the
// word is read in the accept cycle and returned from S_RDATA. Range request:
// S_BOUND, S_LIMIT, then per page a directory read, a table read and an
// optional write-back on the single memory port.
// After reset a clearing sweep writes zero to all MEM_WORDS entries, one per
// cycle; busy stays high until it ends. Config writes are taken at any time.
// The result side cannot stall. MEM_WORDS must be a power of two.
`timescale 1ns / 1ps
`default_nettype none

module user_range_page_walk_check_top
  import urpw_pkg::*;
#(
  parameter int MEM_WORDS = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  req_type,
  input  wire logic [31:0] word_addr,
  input  wire logic [31:0] word_data,
  input  wire logic [31:0] virt_addr,
  input  wire logic [31:0] range_size,
  input  wire logic        want_write,
  input  wire logic        make_writable,
  input  wire logic [31:0] space_root,
  output logic             done,
  output logic      [31:0] read_data,
  output logic      [1:0]  status,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [32:0] cfg_data
);

  localparam int AW = $clog2(MEM_WORDS);

  state_t state, state_next;

  // configuration
  logic [31:0] user_low;
  logic [32:0] user_high;
  logic [31:0] cur_root;

  // latched request
  logic [1:0]  kind;
  logic [31:0] va;
  logic [31:0] span;
  logic        size_zero;
  logic        wr_need;
  logic        mk;
  logic [31:0] root;
  logic [31:0] last;
  logic [19:0] cur_pg;
  logic [19:0] end_pg;
  logic [AW-1:0] tab_idx;
  logic [AW-1:0] clr_cnt;

  // memory port
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_wdata;
  logic [31:0]   mem_rdata;

  // response
  logic        rsp_fire;
  logic [1:0]  rsp_status;
  logic [31:0] rsp_data;

  logic [32:0] last_sum;
  logic        bound_fail;
  logic        limit_fail;
  logic        entry_ok;
  logic        last_page;
  logic        clr_last;
  logic [31:0] dir_byte;
  logic [31:0] tab_byte;

  urpw_mem #(
    .WORDS (MEM_WORDS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign busy = (state != S_IDLE);

  assign last_sum   = {1'b0, va} + {1'b0, span};
  assign bound_fail = (va < user_low) || last_sum[32];
  assign limit_fail = ({1'b0, last} >= user_high) ||
                      ((kind == REQ_PERM) && (root == 32'd0));
  // present and user always, writable only for a check that asks for it
  assign entry_ok   = mem_rdata[BIT_PRESENT] && mem_rdata[BIT_USER] &&
                      (mem_rdata[BIT_WRITE] || !wr_need);
  assign last_page  = (cur_pg == end_pg);
  assign clr_last   = (clr_cnt == AW'(MEM_WORDS - 1));

  // frame bits are 4 KiB aligned, so slot offsets never carry
  assign dir_byte = {root[31:12], cur_pg[19:10], 2'b00};
  assign tab_byte = {mem_rdata[31:12], cur_pg[9:0], 2'b00};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_last) state_next = S_IDLE;
      S_IDLE: begin
        if (start) begin
          unique case (req_type)
            REQ_WRITE: state_next = S_IDLE;
            REQ_READ:  state_next = S_RDATA;
            REQ_CHECK: state_next = S_BOUND;
            REQ_PERM:  state_next = S_BOUND;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_RDATA: state_next = S_IDLE;
      S_BOUND: begin
        if (size_zero || bound_fail) state_next = S_IDLE;
        else                         state_next = S_LIMIT;
      end
      S_LIMIT: begin
        if (limit_fail) state_next = S_IDLE;
        else            state_next = S_DIR;
      end
      S_DIR: state_next = S_DIRW;
      S_DIRW: begin
        if (entry_ok) state_next = S_TABW;
        else          state_next = S_IDLE;
      end
      S_TABW: begin
        if (!entry_ok || last_page) state_next = S_IDLE;
        else                        state_next = S_DIR;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memory port and response
  always_comb begin
    mem_we     = 1'b0;
    mem_addr   = '0;
    mem_wdata  = '0;
    rsp_fire   = 1'b0;
    rsp_status = STAT_OK;
    rsp_data   = '0;
    unique case (state)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_cnt;
      end
      S_IDLE: begin
        mem_addr = word_addr[AW+1:2];
        if (start && (req_type == REQ_WRITE)) begin
          mem_we    = 1'b1;
          mem_wdata = word_data;
          rsp_fire  = 1'b1;
        end
      end
      S_RDATA: begin
        rsp_fire = 1'b1;
        rsp_data = mem_rdata;
      end
      S_BOUND: begin
        if (size_zero) begin
          rsp_fire = 1'b1;
        end else if (bound_fail) begin
          rsp_fire   = 1'b1;
          rsp_status = STAT_BOUNDS;
        end
      end
      S_LIMIT: begin
        if (limit_fail) begin
          rsp_fire   = 1'b1;
          rsp_status = STAT_BOUNDS;
        end
      end
      S_DIR: mem_addr = dir_byte[AW+1:2];
      S_DIRW: begin
        if (entry_ok) begin
          mem_addr = tab_byte[AW+1:2];
        end else begin
          rsp_fire   = 1'b1;
          rsp_status = STAT_FAULT;
        end
      end
      S_TABW: begin
        mem_addr = tab_idx;
        if (!entry_ok) begin
          rsp_fire   = 1'b1;
          rsp_status = STAT_FAULT;
        end else begin
          if (kind == REQ_PERM) begin
            mem_we    = 1'b1;
            mem_wdata = {mem_rdata[31:2], mk, mem_rdata[0]};
          end
          rsp_fire = last_page;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= rsp_fire;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      user_low  <= LOW_RESET;
      user_high <= HIGH_RESET;
      cur_root  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOW:  user_low  <= cfg_data[31:0];
        CFG_HIGH: user_high <= cfg_data;
        CFG_ROOT: cur_root  <= cfg_data[31:0];
        default:  ;
      endcase
    end
  end

  // request and walk registers
  always_ff @(posedge clk) begin
    if (rsp_fire) begin
      read_data <= rsp_data;
      status    <= rsp_status;
    end
    if ((state == S_IDLE) && start) begin
      kind      <= req_type;
      va        <= virt_addr;
      span      <= range_size - 32'd1;
      size_zero <= (range_size == 32'd0);
      wr_need   <= (req_type == REQ_CHECK) && want_write;
      mk        <= make_writable;
      root      <= (req_type == REQ_CHECK) ? cur_root : space_root;
    end
    if (state == S_BOUND) begin
      last <= last_sum[31:0];
    end
    if (state == S_LIMIT) begin
      cur_pg <= va[31:12];
      end_pg <= last[31:12];
    end
    if (state == S_DIRW) begin
      tab_idx <= tab_byte[AW+1:2];
    end
    if ((state == S_TABW) && !last_page) begin
      cur_pg <= cur_pg + 20'd1;
    end
  end

`ifndef SYNTH
  a_range_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req_type == REQ_CHECK || req_type == REQ_PERM)) |=> busy)
    else $error("range request did not hold busy");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == STAT_OK || status == STAT_BOUNDS || status == STAT_FAULT))
    else $error("unknown status code");

  a_read_data_only_reads: assert property (@(posedge clk) disable iff (rst)
    (done && (read_data != 32'd0)) |-> $past(state == S_RDATA))
    else $error("read data on a non-read result");

  a_walk_write_perm: assert property (@(posedge clk) disable iff (rst)
    (mem_we && (state == S_TABW)) |-> (kind == REQ_PERM))
    else $error("table write outside a permission change");

  a_no_done_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |=> !done)
    else $error("result during clearing sweep");
`endif

endmodule : user_range_page_walk_check_top

`default_nettype wire
